// ===== design/bsm_pkg.sv =====
// Shared constants and widths for the bounded simplex minimizer.
// Used by the multiplier, the divider and the top level; no dependencies.
`default_nettype none

package bsm_pkg;

  // largest number of variables held in the simplex
  localparam int MAX_VARS = 4;
  localparam int NVERT    = MAX_VARS + 1;
  // coordinate index width and row or rank width
  localparam int VW = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
  localparam int RW = $clog2(NVERT + 1);

  // shared multiplier: 34-bit magnitude times 31-bit coefficient
  localparam int MUL_AW = 34;
  localparam int MUL_BW = 31;
  localparam int MUL_HW = MUL_AW / 2;
  localparam int MUL_PW = MUL_AW + MUL_BW;

  // centroid divider: 37-bit dividend, divisor is the variable count
  localparam int DIV_NW = 37;

  // handshake between the sequencer and an arithmetic unit
  typedef struct packed {
    logic start;
  } unit_req_t;

  typedef struct packed {
    logic done;
  } unit_rsp_t;

endpackage

`default_nettype wire

// ===== design/bsm_mul.sv =====
// Shared multi-cycle multiplier for scaling and tolerance products.
// Two partial products of half the first operand each; depends on bsm_pkg.
`default_nettype none

module bsm_mul import bsm_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire unit_req_t         req,
  input  wire logic [MUL_AW-1:0] a,
  input  wire logic [MUL_BW-1:0] b,
  output unit_rsp_t              rsp,
  output logic      [MUL_PW-1:0] p
);

  logic [1:0]        ph;
  logic [MUL_HW-1:0] lo;
  logic [MUL_HW-1:0] hi;
  logic [MUL_BW-1:0] bq;
  logic [MUL_PW-1:0] acc;
  logic              dn;

  // step control
  always_ff @(posedge clk) begin
    if (rst) begin
      ph <= 2'd0;
      dn <= 1'b0;
    end else begin
      dn <= 1'b0;
      case (ph)
        2'd0: if (req.start) ph <= 2'd1;
        2'd1: ph <= 2'd2;
        2'd2: begin
          ph <= 2'd0;
          dn <= 1'b1;
        end
        default: ph <= 2'd0;
      endcase
    end
  end

  // operand capture and accumulation
  always_ff @(posedge clk) begin
    if (ph == 2'd0 && req.start) begin
      lo <= a[MUL_HW-1:0];
      hi <= a[MUL_AW-1:MUL_HW];
      bq <= b;
    end
    if (ph == 2'd1) acc <= MUL_PW'(lo) * MUL_PW'(bq);
    if (ph == 2'd2) acc <= acc + ((MUL_PW'(hi) * MUL_PW'(bq)) << MUL_HW);
  end

  assign rsp.done = dn;
  assign p        = acc;

endmodule

`default_nettype wire

// ===== design/bsm_div.sv =====
// Bit-serial restoring divider for the centroid mean, one quotient bit a cycle.
// Divisor is the small variable count; depends on bsm_pkg.
`default_nettype none

module bsm_div import bsm_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire unit_req_t         req,
  input  wire logic [DIV_NW-1:0] num,
  input  wire logic [RW-1:0]     den,
  output unit_rsp_t              rsp,
  output logic      [DIV_NW-1:0] q
);

  localparam int CW = $clog2(DIV_NW + 1);

  logic [DIV_NW-1:0] dvd;
  logic [RW-1:0]     rem;
  logic [RW-1:0]     dq;
  logic [CW-1:0]     cnt;
  logic              busy;
  logic              dn;
  logic [RW:0]       rem_s;
  logic              qbit;

  // one shift-subtract step
  always_comb begin
    rem_s = {rem, dvd[DIV_NW-1]};
    qbit  = (rem_s >= {1'b0, dq});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      dn   <= 1'b0;
      cnt  <= '0;
    end else begin
      dn <= 1'b0;
      if (!busy) begin
        if (req.start) begin
          busy <= 1'b1;
          cnt  <= CW'(DIV_NW);
        end
      end else begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          dn   <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (!busy && req.start) begin
      dvd <= num;
      dq  <= den;
      rem <= '0;
    end else if (busy) begin
      rem <= qbit ? RW'(rem_s - {1'b0, dq}) : rem_s[RW-1:0];
      dvd <= {dvd[DIV_NW-2:0], qbit};
    end
  end

  assign rsp.done = dn;
  assign q        = dvd;

endmodule

`default_nettype wire

// ===== design/bounded_simplex_minimizer.sv =====
// Box-bounded Nelder-Mead minimizer, signed Q16.16, top level and sequencer.
// Uses bsm_pkg, the shared multiplier bsm_mul and the divider bsm_div.
//
// Usage: the slave stream takes items, the kind in s_tuser (0 load variable,
// 1 start search, 2 objective value). A load beat stores one variable's start,
// step and bounds. A start beat builds the simplex and sends its first vertex
// on the master stream, one beat per coordinate, tlast on the last one. Each
// objective value beat answers the point last sent; the block replies with the
// next point, or the final best point with finished (and converged) set in
// m_tuser. The config channel is always ready and writes one register a beat.
// A value that completes an iteration sorts the vertices, tests the tolerance
// and builds a new point coordinate by coordinate with the centroid divider and
// the shared multiplier.
// s_tready is high only while the sequencer is idle, one item at a time.
// The output register holds a beat while m_tready is low; the sequencer waits
// behind it, and an item may be accepted while the final beat still waits.
// Reset (rst, synchronous) returns the search to idle and the registers to
// their defaults; the stored variables stay undefined until loaded.
`default_nettype none

module bounded_simplex_minimizer import bsm_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // var_index, start_value, step_length, upper_limit, lower_limit, objective_value
  input  wire logic [167:0] s_tdata,
  // opcode
  input  wire logic [1:0]   s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // coord_index, coord_value, iterations
  output logic [47:0]       m_tdata,
  // finished, converged
  output logic [1:0]        m_tuser,
  output logic              m_tlast,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [31:0]  cfg_data
);

  // item kinds
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_VALUE = 2'd2;

  // register indexes
  localparam logic [2:0] R_ACTIVE   = 3'd0;
  localparam logic [2:0] R_MAXIT    = 3'd1;
  localparam logic [2:0] R_RELTOL   = 3'd2;
  localparam logic [2:0] R_ABSTOL   = 3'd3;
  localparam logic [2:0] R_REFLECT  = 3'd4;
  localparam logic [2:0] R_EXPAND   = 3'd5;
  localparam logic [2:0] R_CONTRACT = 3'd6;
  localparam logic [2:0] R_SHRINK   = 3'd7;

  // search phases
  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_INIT     = 3'd1;
  localparam logic [2:0] PH_REFLECT  = 3'd2;
  localparam logic [2:0] PH_EXPAND   = 3'd3;
  localparam logic [2:0] PH_CONTRACT = 3'd4;
  localparam logic [2:0] PH_SHRINK   = 3'd5;
  localparam logic [2:0] PH_DONE     = 3'd6;

  // sequencer states
  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_BUILD    = 5'd1;
  localparam logic [4:0] S_EMIT     = 5'd2;
  localparam logic [4:0] S_SUMS     = 5'd3;
  localparam logic [4:0] S_SORT_LD  = 5'd4;
  localparam logic [4:0] S_SORT_CMP = 5'd5;
  localparam logic [4:0] S_CACHE    = 5'd6;
  localparam logic [4:0] S_DECIDE   = 5'd7;
  localparam logic [4:0] S_TOL_MUL  = 5'd8;
  localparam logic [4:0] S_TOL_RDB  = 5'd9;
  localparam logic [4:0] S_TOL_RDW  = 5'd10;
  localparam logic [4:0] S_TOL_CMUL = 5'd11;
  localparam logic [4:0] S_TOL_END  = 5'd12;
  localparam logic [4:0] S_NP_RD    = 5'd13;
  localparam logic [4:0] S_NP_DIV   = 5'd14;
  localparam logic [4:0] S_NP_MUL   = 5'd15;
  localparam logic [4:0] S_REPL     = 5'd16;
  localparam logic [4:0] S_SHR_RDB  = 5'd17;
  localparam logic [4:0] S_SHR_RDV  = 5'd18;
  localparam logic [4:0] S_SHR_MUL  = 5'd19;

  localparam logic signed [49:0] SAT_HI = 50'sd2147483647;
  localparam logic signed [49:0] SAT_LO = -50'sd2147483648;

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    mag32 = v[31] ? 32'(-v) : 32'(v);
  endfunction

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    mag33 = v[32] ? 33'(-v) : 33'(v);
  endfunction

  function automatic logic [33:0] mag34(input logic signed [33:0] v);
    mag34 = v[33] ? 34'(-v) : 34'(v);
  endfunction

  // configuration
  logic [3:0]  active_vars;
  logic [9:0]  max_iterations;
  logic [30:0] rel_tol;
  logic [30:0] abs_tol;
  logic [30:0] reflect_coef;
  logic [30:0] expand_coef;
  logic [30:0] contract_coef;
  logic [30:0] shrink_coef;

  // stores
  logic signed [31:0] coords [NVERT][MAX_VARS];
  logic signed [31:0] vals [NVERT];
  logic signed [34:0] sums [MAX_VARS];
  logic signed [31:0] trial [MAX_VARS];
  logic signed [31:0] saved [MAX_VARS];
  logic signed [31:0] ubnd [MAX_VARS];
  logic signed [31:0] lbnd [MAX_VARS];
  logic signed [31:0] spnt [MAX_VARS];
  logic signed [31:0] stps [MAX_VARS];
  logic signed [31:0] saved_val;
  logic [RW-1:0]      ord [NVERT];

  // control
  logic [4:0]    st;
  logic [2:0]    phase;
  logic [RW-1:0] pending;
  logic [9:0]    iter;
  logic [RW-1:0] nv;
  logic [VW-1:0] ci;
  logic [RW-1:0] rj;
  logic [RW-1:0] si;
  logic [RW-1:0] sj;
  logic [RW-1:0] ej;
  logic          after;
  logic          tol_ok;

  // working registers
  logic signed [31:0] cur;
  logic signed [31:0] v0;
  logic signed [31:0] vsec;
  logic signed [31:0] vworst;
  logic signed [34:0] acc;
  logic [32:0]        spread;
  logic [32:0]        tol_d;
  logic signed [31:0] base_c;
  logic signed [32:0] shr_d;
  logic [30:0]        np_k;
  logic               np_neg;
  logic               np_nneg;
  logic signed [31:0] np_w;
  logic signed [32:0] np_c;
  logic signed [33:0] np_d;
  logic               repl_src;
  logic signed [31:0] repl_val;

  // emission
  logic          emit_src;
  logic [RW-1:0] emit_rank;
  logic          emit_fin;
  logic          emit_conv;
  logic          ov;
  logic [2:0]    o_idx;
  logic [31:0]   o_val;
  logic          o_last;
  logic          o_fin;
  logic          o_conv;
  logic [9:0]    o_iter;

  // arithmetic units
  unit_req_t          mul_req;
  unit_rsp_t          mul_rsp;
  logic [MUL_AW-1:0]  mul_a;
  logic [MUL_BW-1:0]  mul_b;
  logic [MUL_PW-1:0]  mul_p;
  unit_req_t          div_req;
  unit_rsp_t          div_rsp;
  logic [DIV_NW-1:0]  div_n;
  logic [DIV_NW-1:0]  div_q;

  // input fields
  logic [1:0]         in_op;
  logic [2:0]         in_k;
  logic signed [31:0] in_start;
  logic signed [31:0] in_step;
  logic signed [31:0] in_ub;
  logic signed [31:0] in_lb;
  logic signed [31:0] in_f;

  // read ports and derived values
  logic [RW-1:0]      cr_row;
  logic [VW-1:0]      cr_col;
  logic [RW-1:0]      vr_row;
  logic signed [31:0] coord_rd;
  logic signed [31:0] val_rd;
  logic               lastc;
  logic               running;
  logic [RW-1:0]      nv_start;
  logic signed [32:0] bld_t;
  logic signed [32:0] bld_c;
  logic signed [31:0] bld_v;
  logic signed [35:0] np_num;
  logic [35:0]        np_mag;
  logic [36:0]        np_dvd;
  logic signed [32:0] np_cq;
  logic signed [33:0] np_dq;
  logic [64:0]        rnd;
  logic [48:0]        rmag;
  logic signed [49:0] rs_np;
  logic signed [49:0] rs_sh;
  logic signed [49:0] np_t;
  logic signed [49:0] np_tc;
  logic signed [49:0] sh_t;
  logic signed [31:0] sh_res;
  logic signed [32:0] diff_cb;
  logic signed [31:0] repl_p;

  assign in_op    = s_tuser;
  assign in_k     = s_tdata[2:0];
  assign in_start = s_tdata[34:3];
  assign in_step  = s_tdata[66:35];
  assign in_ub    = s_tdata[98:67];
  assign in_lb    = s_tdata[130:99];
  assign in_f     = s_tdata[162:131];

  assign s_tready  = (st == S_IDLE);
  assign cfg_ready = 1'b1;
  assign m_tvalid  = ov;
  assign m_tdata   = {3'b000, o_iter, o_val, o_idx};
  assign m_tuser   = {o_conv, o_fin};
  assign m_tlast   = o_last;

  assign mul_req.start = 1'b0 | mul_go;
  assign div_req.start = 1'b0 | div_go;

  logic mul_go;
  logic div_go;

  bsm_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .a   (mul_a),
    .b   (mul_b),
    .rsp (mul_rsp),
    .p   (mul_p)
  );

  bsm_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .num (div_n),
    .den (nv),
    .rsp (div_rsp),
    .q   (div_q)
  );

  // read address selection
  always_comb begin
    cr_row = ord[0];
    cr_col = ci;
    vr_row = ord[0];
    case (st)
      S_EMIT:     begin
        cr_row = ord[emit_rank];
        cr_col = ej[VW-1:0];
      end
      S_SUMS:     cr_row = rj;
      S_SORT_LD:  vr_row = ord[si];
      S_SORT_CMP: vr_row = ord[sj];
      S_CACHE: begin
        if (rj == RW'(0))      vr_row = ord[0];
        else if (rj == RW'(1)) vr_row = ord[nv - RW'(1)];
        else                   vr_row = ord[nv];
      end
      S_TOL_RDW, S_NP_RD, S_REPL: cr_row = ord[nv];
      S_SHR_RDV:  cr_row = ord[rj];
      default: ;
    endcase
  end

  assign coord_rd = coords[cr_row][cr_col];
  assign val_rd   = vals[vr_row];
  assign lastc    = (RW'(ci) + RW'(1) == nv);
  assign running  = (phase != PH_IDLE) && (phase != PH_DONE);

  // datapath arithmetic
  always_comb begin
    if (active_vars == 4'd0)                 nv_start = RW'(1);
    else if (active_vars > 4'(MAX_VARS))     nv_start = RW'(MAX_VARS);
    else                                     nv_start = RW'(active_vars);

    // initial vertex offset, clamped to upper then lower bound
    bld_t = $signed({spnt[ci][31], spnt[ci]}) + $signed({stps[ci][31], stps[ci]});
    bld_c = bld_t;
    if (bld_c > $signed({ubnd[ci][31], ubnd[ci]})) bld_c = $signed({ubnd[ci][31], ubnd[ci]});
    if (bld_c < $signed({lbnd[ci][31], lbnd[ci]})) bld_c = $signed({lbnd[ci][31], lbnd[ci]});
    if (rj != RW'(0) && RW'(ci) == rj - RW'(1)) bld_v = bld_c[31:0];
    else                                        bld_v = spnt[ci];

    // centroid numerator without the worst vertex
    np_num = $signed({sums[ci][34], sums[ci]}) - $signed({{4{coord_rd[31]}}, coord_rd});
    np_mag = np_num[35] ? 36'(-np_num) : 36'(np_num);
    np_dvd = {1'b0, np_mag} + 37'(nv >> 1);
    np_cq  = np_nneg ? -$signed({1'b0, div_q[31:0]}) : $signed({1'b0, div_q[31:0]});
    np_dq  = $signed({np_cq[32], np_cq}) - $signed({{2{np_w[31]}}, np_w});

    // rounded coefficient product
    rnd   = mul_p + 65'd32768;
    rmag  = rnd[64:16];
    rs_np = (np_d[33] ^ np_neg) ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
    rs_sh = shr_d[32] ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});

    // trial coordinate, raised to lower then lowered to upper bound
    np_t  = $signed({{17{np_c[32]}}, np_c}) + rs_np;
    np_tc = np_t;
    if (np_tc < $signed({{18{lbnd[ci][31]}}, lbnd[ci]})) np_tc = $signed({{18{lbnd[ci][31]}}, lbnd[ci]});
    if (np_tc > $signed({{18{ubnd[ci][31]}}, ubnd[ci]})) np_tc = $signed({{18{ubnd[ci][31]}}, ubnd[ci]});

    // shrunk coordinate, saturated
    sh_t = $signed({{18{base_c[31]}}, base_c}) + rs_sh;
    if (sh_t > SAT_HI)      sh_res = 32'sh7fffffff;
    else if (sh_t < SAT_LO) sh_res = 32'sh80000000;
    else                    sh_res = sh_t[31:0];

    diff_cb = $signed({coord_rd[31], coord_rd}) - $signed({base_c[31], base_c});
    repl_p  = repl_src ? saved[ci] : trial[ci];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      st             <= S_IDLE;
      phase          <= PH_IDLE;
      pending        <= '0;
      iter           <= '0;
      nv             <= RW'(1);
      ov             <= 1'b0;
      mul_go         <= 1'b0;
      div_go         <= 1'b0;
      active_vars    <= 4'd2;
      max_iterations <= 10'd100;
      rel_tol        <= 31'd13;
      abs_tol        <= 31'd0;
      reflect_coef   <= 31'd65536;
      expand_coef    <= 31'd131072;
      contract_coef  <= 31'd32768;
      shrink_coef    <= 31'd32768;
    end else begin
      mul_go <= 1'b0;
      div_go <= 1'b0;
      if (m_tready) ov <= 1'b0;

      // register writes
      if (cfg_valid) begin
        case (cfg_index)
          R_ACTIVE:   active_vars    <= cfg_data[3:0];
          R_MAXIT:    max_iterations <= cfg_data[9:0];
          R_RELTOL:   rel_tol        <= cfg_data[30:0];
          R_ABSTOL:   abs_tol        <= cfg_data[30:0];
          R_REFLECT:  reflect_coef   <= cfg_data[30:0];
          R_EXPAND:   expand_coef    <= cfg_data[30:0];
          R_CONTRACT: contract_coef  <= cfg_data[30:0];
          R_SHRINK:   shrink_coef    <= cfg_data[30:0];
          default: ;
        endcase
      end

      case (st)
        // take one item
        S_IDLE: begin
          if (s_tvalid) begin
            case (in_op)
              OP_LOAD: begin
                if ({1'b0, in_k} < 4'(MAX_VARS) && !running) begin
                  spnt[in_k[VW-1:0]] <= in_start;
                  stps[in_k[VW-1:0]] <= in_step;
                  ubnd[in_k[VW-1:0]] <= in_ub;
                  lbnd[in_k[VW-1:0]] <= in_lb;
                end
              end
              OP_START: begin
                nv <= nv_start;
                for (int r = 0; r < NVERT; r++) ord[r] <= RW'(r);
                iter    <= '0;
                pending <= '0;
                phase   <= PH_INIT;
                rj      <= '0;
                ci      <= '0;
                st      <= S_BUILD;
              end
              OP_VALUE: begin
                case (phase)
                  PH_INIT, PH_SHRINK: begin
                    vals[ord[pending]] <= in_f;
                    pending <= pending + RW'(1);
                    if (pending + RW'(1) <= nv) begin
                      emit_src  <= 1'b0;
                      emit_rank <= pending + RW'(1);
                      emit_fin  <= 1'b0;
                      emit_conv <= 1'b0;
                      ej        <= '0;
                      st        <= S_EMIT;
                    end else begin
                      after <= (phase == PH_SHRINK);
                      acc   <= '0;
                      rj    <= '0;
                      ci    <= '0;
                      st    <= S_SUMS;
                    end
                  end
                  PH_REFLECT: begin
                    ci <= '0;
                    if (in_f < vsec && in_f > v0) begin
                      repl_src <= 1'b0;
                      repl_val <= in_f;
                      st       <= S_REPL;
                    end else if (in_f < v0) begin
                      for (int i = 0; i < MAX_VARS; i++) saved[i] <= trial[i];
                      saved_val <= in_f;
                      np_k      <= expand_coef;
                      np_neg    <= 1'b0;
                      phase     <= PH_EXPAND;
                      st        <= S_NP_RD;
                    end else begin
                      np_k   <= contract_coef;
                      np_neg <= 1'b1;
                      phase  <= PH_CONTRACT;
                      st     <= S_NP_RD;
                    end
                  end
                  PH_EXPAND: begin
                    ci <= '0;
                    if (in_f < saved_val) begin
                      repl_src <= 1'b0;
                      repl_val <= in_f;
                    end else begin
                      repl_src <= 1'b1;
                      repl_val <= saved_val;
                    end
                    st <= S_REPL;
                  end
                  PH_CONTRACT: begin
                    ci <= '0;
                    if (in_f < vworst) begin
                      repl_src <= 1'b0;
                      repl_val <= in_f;
                      st       <= S_REPL;
                    end else begin
                      rj <= RW'(1);
                      st <= S_SHR_RDB;
                    end
                  end
                  default: ;
                endcase
              end
              default: ;
            endcase
          end
        end

        // initial simplex, one coordinate a cycle
        S_BUILD: begin
          coords[rj][ci] <= bld_v;
          if (lastc) begin
            ci <= '0;
            if (rj == nv) begin
              emit_src  <= 1'b0;
              emit_rank <= '0;
              emit_fin  <= 1'b0;
              emit_conv <= 1'b0;
              ej        <= '0;
              st        <= S_EMIT;
            end else begin
              rj <= rj + RW'(1);
            end
          end else begin
            ci <= ci + 1'b1;
          end
        end

        // send one point, a beat per coordinate
        S_EMIT: begin
          if (ej < nv) begin
            if (!ov || m_tready) begin
              ov     <= 1'b1;
              o_idx  <= 3'(ej);
              o_val  <= emit_src ? trial[ej[VW-1:0]] : coord_rd;
              o_last <= (ej + RW'(1) == nv);
              o_fin  <= emit_fin;
              o_conv <= emit_conv;
              o_iter <= iter;
              ej     <= ej + RW'(1);
            end
          end else begin
            st <= S_IDLE;
          end
        end

        // coordinate sums over all vertices
        S_SUMS: begin
          if (rj == nv) begin
            sums[ci] <= acc + $signed({{3{coord_rd[31]}}, coord_rd});
            acc <= '0;
            rj  <= '0;
            if (lastc) begin
              si <= '0;
              st <= S_SORT_LD;
            end else begin
              ci <= ci + 1'b1;
            end
          end else begin
            acc <= acc + $signed({{3{coord_rd[31]}}, coord_rd});
            rj  <= rj + RW'(1);
          end
        end

        // exchange sort on the rank table
        S_SORT_LD: begin
          cur <= val_rd;
          sj  <= si + RW'(1);
          st  <= S_SORT_CMP;
        end

        S_SORT_CMP: begin
          if (val_rd < cur) begin
            ord[si] <= ord[sj];
            ord[sj] <= ord[si];
            cur     <= val_rd;
          end
          if (sj == nv) begin
            if (si + RW'(1) == nv) begin
              rj <= '0;
              st <= S_CACHE;
            end else begin
              si <= si + RW'(1);
              st <= S_SORT_LD;
            end
          end else begin
            sj <= sj + RW'(1);
          end
        end

        // best, second worst and worst values
        S_CACHE: begin
          if (rj == RW'(0)) begin
            v0 <= val_rd;
            rj <= RW'(1);
          end else if (rj == RW'(1)) begin
            vsec <= val_rd;
            rj   <= RW'(2);
          end else begin
            vworst <= val_rd;
            st     <= S_DECIDE;
          end
        end

        // iteration limit, then value tolerance
        S_DECIDE: begin
          if (after && iter >= max_iterations) begin
            phase     <= PH_DONE;
            emit_src  <= 1'b0;
            emit_rank <= '0;
            emit_fin  <= 1'b1;
            emit_conv <= 1'b0;
            ej        <= '0;
            st        <= S_EMIT;
          end else begin
            spread <= mag33($signed({vworst[31], vworst}) - $signed({v0[31], v0}));
            mul_a  <= MUL_AW'(mag32(v0)) + MUL_AW'(1);
            mul_b  <= rel_tol;
            mul_go <= 1'b1;
            st     <= S_TOL_MUL;
          end
        end

        S_TOL_MUL: begin
          if (mul_rsp.done) begin
            ci <= '0;
            if ((MUL_PW'(spread) << 16) < mul_p || spread < 33'(abs_tol)) begin
              tol_ok <= 1'b1;
              st     <= S_TOL_END;
            end else if (rel_tol == 31'd0) begin
              tol_ok <= 1'b0;
              st     <= S_TOL_END;
            end else begin
              st <= S_TOL_RDB;
            end
          end
        end

        // coordinate tolerance, one coordinate at a time
        S_TOL_RDB: begin
          base_c <= coord_rd;
          st     <= S_TOL_RDW;
        end

        S_TOL_RDW: begin
          if (diff_cb == 33'sd0) begin
            if (lastc) begin
              tol_ok <= 1'b1;
              st     <= S_TOL_END;
            end else begin
              ci <= ci + 1'b1;
              st <= S_TOL_RDB;
            end
          end else begin
            tol_d  <= mag33(diff_cb);
            mul_a  <= MUL_AW'(mag32(base_c));
            mul_b  <= rel_tol;
            mul_go <= 1'b1;
            st     <= S_TOL_CMUL;
          end
        end

        S_TOL_CMUL: begin
          if (mul_rsp.done) begin
            if (!((MUL_PW'(tol_d) << 16) < mul_p)) begin
              tol_ok <= 1'b0;
              st     <= S_TOL_END;
            end else if (lastc) begin
              tol_ok <= 1'b1;
              st     <= S_TOL_END;
            end else begin
              ci <= ci + 1'b1;
              st <= S_TOL_RDB;
            end
          end
        end

        S_TOL_END: begin
          if (tol_ok) begin
            phase     <= PH_DONE;
            emit_src  <= 1'b0;
            emit_rank <= '0;
            emit_fin  <= 1'b1;
            emit_conv <= 1'b1;
            ej        <= '0;
            st        <= S_EMIT;
          end else begin
            iter   <= iter + 10'd1;
            np_k   <= reflect_coef;
            np_neg <= 1'b0;
            phase  <= PH_REFLECT;
            ci     <= '0;
            st     <= S_NP_RD;
          end
        end

        // new trial point: centroid, scaled offset, clamp
        S_NP_RD: begin
          np_w    <= coord_rd;
          np_nneg <= np_num[35];
          div_n   <= np_dvd;
          div_go  <= 1'b1;
          st      <= S_NP_DIV;
        end

        S_NP_DIV: begin
          if (div_rsp.done) begin
            np_c   <= np_cq;
            np_d   <= np_dq;
            mul_a  <= mag34(np_dq);
            mul_b  <= np_k;
            mul_go <= 1'b1;
            st     <= S_NP_MUL;
          end
        end

        S_NP_MUL: begin
          if (mul_rsp.done) begin
            trial[ci] <= np_tc[31:0];
            if (lastc) begin
              emit_src  <= 1'b1;
              emit_rank <= '0;
              emit_fin  <= 1'b0;
              emit_conv <= 1'b0;
              ej        <= '0;
              st        <= S_EMIT;
            end else begin
              ci <= ci + 1'b1;
              st <= S_NP_RD;
            end
          end
        end

        // worst vertex replaced, sums kept up to date
        S_REPL: begin
          sums[ci] <= sums[ci] + $signed({{3{repl_p[31]}}, repl_p})
                      - $signed({{3{coord_rd[31]}}, coord_rd});
          coords[ord[nv]][ci] <= repl_p;
          if (lastc) begin
            vals[ord[nv]] <= repl_val;
            after <= 1'b1;
            si    <= '0;
            st    <= S_SORT_LD;
          end else begin
            ci <= ci + 1'b1;
          end
        end

        // shrink every vertex but the best toward the best one
        S_SHR_RDB: begin
          base_c <= coord_rd;
          st     <= S_SHR_RDV;
        end

        S_SHR_RDV: begin
          shr_d  <= diff_cb;
          mul_a  <= {1'b0, mag33(diff_cb)};
          mul_b  <= shrink_coef;
          mul_go <= 1'b1;
          st     <= S_SHR_MUL;
        end

        S_SHR_MUL: begin
          if (mul_rsp.done) begin
            coords[ord[rj]][ci] <= sh_res;
            if (lastc) begin
              ci <= '0;
              if (rj == nv) begin
                pending   <= RW'(1);
                phase     <= PH_SHRINK;
                emit_src  <= 1'b0;
                emit_rank <= RW'(1);
                emit_fin  <= 1'b0;
                emit_conv <= 1'b0;
                ej        <= '0;
                st        <= S_EMIT;
              end else begin
                rj <= rj + RW'(1);
                st <= S_SHR_RDB;
              end
            end else begin
              ci <= ci + 1'b1;
              st <= S_SHR_RDB;
            end
          end
        end

        default: st <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
